// ===== rtl/owb_pkg.sv =====
// Shared types and constants for the one-wire bus master.
// No dependencies; imported by every module of the block.
`default_nettype none

package owb_pkg;

    localparam int CFG_COUNT = 7;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WR_ONE_LOW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_LOW       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_RECOVER   = 3'd6;

    typedef logic [CFG_COUNT-1:0][CFG_W-1:0] t_cfg;

    localparam t_cfg CFG_RESET_VALUES = {
        10'd60,  // read recover
        10'd2,   // read low
        10'd50,  // slot
        10'd1,   // write one low
        10'd400, // reset tail
        10'd80,  // presence wait
        10'd480  // reset low
    };

    typedef struct packed {
        logic       pull_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_byte;
        logic       status;
    } t_owb_res;

endpackage

`default_nettype wire

// ===== rtl/owb_cfg.sv =====
// Timing register file of the one-wire bus master.
// Depends on owb_pkg for the register indexes and reset values.
`default_nettype none

module owb_cfg
    import owb_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [CFG_W-1:0]     i_wr_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET_VALUES;
        end else if (i_wr_en && (i_wr_index < CFG_IDX_W'(CFG_COUNT))) begin
            r_cfg[i_wr_index] <= i_wr_data;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/owb_engine.sv =====
// Bus timing sequencer: holds phase, tick count, bit position and data byte,
// and works out one tick per step. Depends on owb_pkg.
`default_nettype none

module owb_engine
    import owb_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 10
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [1:0] i_req_type,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_line_level,
    input  wire t_cfg       i_cfg,
    output t_owb_res        o_res
);

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_RESET = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RST_LOW  = 3'd1;
    localparam logic [2:0] PH_RST_WAIT = 3'd2;
    localparam logic [2:0] PH_RST_TAIL = 3'd3;
    localparam logic [2:0] PH_WR_LOW   = 3'd4;
    localparam logic [2:0] PH_WR_HIGH  = 3'd5;
    localparam logic [2:0] PH_RD_LOW   = 3'd6;
    localparam logic [2:0] PH_RD_REC   = 3'd7;

    localparam int TW = TICK_COUNT_WIDTH;

    logic [2:0]    r_phase,      n_phase;
    logic [TW-1:0] r_ticks_left, n_ticks_left;
    logic [3:0]    r_bit_index,  n_bit_index;
    logic [7:0]    r_shift_byte, n_shift_byte;
    logic          r_presence,   n_presence;
    logic          r_first_tick, n_first_tick;
    logic [7:0]    r_last_read,  n_last_read;

    logic run;
    logic drive;
    logic done;
    logic refused;

    // Count loaded at a phase start; zero counts as one tick
    function automatic logic [TW-1:0] load_ticks(input logic [CFG_W-1:0] v);
        logic [15:0]   ext;
        logic [TW-1:0] t;
        ext = 16'(v);
        t   = ext[TW-1:0];
        if (t == '0) begin
            t = TW'(1);
        end
        return t;
    endfunction

    always_comb begin
        n_phase      = r_phase;
        n_ticks_left = r_ticks_left;
        n_bit_index  = r_bit_index;
        n_shift_byte = r_shift_byte;
        n_presence   = r_presence;
        n_first_tick = r_first_tick;
        n_last_read  = r_last_read;
        run          = 1'b0;
        drive        = 1'b0;
        done         = 1'b0;
        refused      = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_req_type != REQ_TICK) begin
                run         = 1'b1;
                n_bit_index = 4'd0;
                n_first_tick = 1'b1;
                case (i_req_type)
                    REQ_RESET: begin
                        n_phase      = PH_RST_LOW;
                        n_ticks_left = load_ticks(i_cfg[CFG_RESET_LOW]);
                    end
                    REQ_WRITE: begin
                        n_shift_byte = i_data_byte;
                        n_phase      = PH_WR_LOW;
                        n_ticks_left = i_data_byte[0] ? load_ticks(i_cfg[CFG_WR_ONE_LOW])
                                                      : load_ticks(i_cfg[CFG_SLOT]);
                    end
                    REQ_READ: begin
                        n_shift_byte = 8'd0;
                        n_phase      = PH_RD_LOW;
                        n_ticks_left = load_ticks(i_cfg[CFG_RD_LOW]);
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end else begin
            run     = 1'b1;
            refused = (i_req_type != REQ_TICK);
        end

        if (run) begin
            drive = (n_phase == PH_RST_LOW) || (n_phase == PH_WR_LOW) ||
                    (n_phase == PH_RD_LOW);
            if (n_first_tick) begin
                if (n_phase == PH_RST_TAIL) begin
                    n_presence = !i_line_level;
                end else if (n_phase == PH_RD_REC) begin
                    n_shift_byte = n_shift_byte |
                                   (8'({7'd0, i_line_level}) << n_bit_index[2:0]);
                end
            end
            n_first_tick = 1'b0;
            if (n_ticks_left != '0) begin
                n_ticks_left = n_ticks_left - TW'(1);
            end
            if (n_ticks_left == '0) begin
                case (n_phase)
                    PH_RST_LOW: begin
                        n_phase      = PH_RST_WAIT;
                        n_ticks_left = load_ticks(i_cfg[CFG_PRESENCE_WAIT]);
                        n_first_tick = 1'b1;
                    end
                    PH_RST_WAIT: begin
                        n_phase      = PH_RST_TAIL;
                        n_ticks_left = load_ticks(i_cfg[CFG_RESET_TAIL]);
                        n_first_tick = 1'b1;
                    end
                    PH_WR_LOW, PH_WR_HIGH: begin
                        if ((n_phase == PH_WR_LOW) && n_shift_byte[n_bit_index[2:0]]) begin
                            n_phase      = PH_WR_HIGH;
                            n_ticks_left = load_ticks(i_cfg[CFG_SLOT]);
                            n_first_tick = 1'b1;
                        end else begin
                            // zero bit has no released tail
                            n_bit_index = n_bit_index + 4'd1;
                            if (n_bit_index[3]) begin
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end else begin
                                n_phase      = PH_WR_LOW;
                                n_ticks_left = n_shift_byte[n_bit_index[2:0]]
                                             ? load_ticks(i_cfg[CFG_WR_ONE_LOW])
                                             : load_ticks(i_cfg[CFG_SLOT]);
                                n_first_tick = 1'b1;
                            end
                        end
                    end
                    PH_RD_LOW: begin
                        n_phase      = PH_RD_REC;
                        n_ticks_left = load_ticks(i_cfg[CFG_RD_RECOVER]);
                        n_first_tick = 1'b1;
                    end
                    PH_RD_REC: begin
                        n_bit_index = n_bit_index + 4'd1;
                        if (n_bit_index[3]) begin
                            n_last_read = n_shift_byte;
                            n_phase     = PH_IDLE;
                            done        = 1'b1;
                        end else begin
                            n_phase      = PH_RD_LOW;
                            n_ticks_left = load_ticks(i_cfg[CFG_RD_LOW]);
                            n_first_tick = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                endcase
            end
            if (n_phase == PH_IDLE) begin
                n_ticks_left = '0;
                n_first_tick = 1'b0;
            end
        end

        o_res.pull_low  = drive;
        o_res.busy_res  = run;
        o_res.done_res  = done;
        o_res.presence  = n_presence;
        o_res.read_byte = n_last_read;
        o_res.status    = refused;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_ticks_left <= '0;
            r_bit_index  <= 4'd0;
            r_shift_byte <= 8'd0;
            r_presence   <= 1'b0;
            r_first_tick <= 1'b0;
            r_last_read  <= 8'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_ticks_left <= n_ticks_left;
            r_bit_index  <= n_bit_index;
            r_shift_byte <= n_shift_byte;
            r_presence   <= n_presence;
            r_first_tick <= n_first_tick;
            r_last_read  <= n_last_read;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/one_wire_bus_master.sv =====
// One-wire bus master, one word per 1 us tick.
// Path from input accept to result: input register, then result register.
// Throughput: one word per cycle while the output is not stalled; each word is worked
// out in a single pass of the sequencer between the two registers.
// Reset (synchronous, active low): sequencer idle, no result valid, timing registers to defaults.
`default_nettype none

module one_wire_bus_master
    import owb_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_line_level,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_pull_low,
    output logic                      o_busy_res,
    output logic                      o_done_res,
    output logic                      o_presence,
    output logic [7:0]                o_read_byte,
    output logic                      o_status,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic       r_in_valid;
    logic [1:0] r_req_type;
    logic [7:0] r_data_byte;
    logic       r_line_level;
    logic       r_out_valid;
    t_owb_res   r_res;
    t_owb_res   step_res;
    t_cfg       cfg;
    logic       advance;
    logic       step;

    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    owb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    owb_engine #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_req_type   (r_req_type),
        .i_data_byte  (r_data_byte),
        .i_line_level (r_line_level),
        .i_cfg        (cfg),
        .o_res        (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_req_type   <= i_req_type;
            r_data_byte  <= i_data_byte;
            r_line_level <= i_line_level;
        end
        if (step) begin
            r_res <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pull_low  = r_res.pull_low;
    assign o_busy_res  = r_res.busy_res;
    assign o_done_res  = r_res.done_res;
    assign o_presence  = r_res.presence;
    assign o_read_byte = r_res.read_byte;
    assign o_status    = r_res.status;

endmodule

`default_nettype wire
